// ----- hw/rtl/bte_pkg.sv -----
package bte_pkg;

    // default sample width, Q1.(SAMPLE_BITS-1)
    localparam int SAMPLE_BITS_DEF = 16;

    // extra fraction bits carried through the weight math
    localparam int FRAC_EXTRA = 20;

    // round(2^20 / sqrt(3)), Q0.20
    localparam int INV_SQRT3_Q = 605396;

    // phase sector codes
    localparam logic [1:0] SECTOR_0 = 2'd0;
    localparam logic [1:0] SECTOR_1 = 2'd1;
    localparam logic [1:0] SECTOR_2 = 2'd2;

    // side info that rides with an item once the sector is known
    typedef struct packed {
        logic       last;
        logic [1:0] sector;
    } bte_ctl_t;

endpackage

// ----- hw/rtl/bte_front.sv -----
module bte_front
    import bte_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] real_part,
    input  logic signed [SAMPLE_BITS-1:0] imag_part,
    input  logic                          last_pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    output logic signed [SAMPLE_BITS+20:0] t_out,
    output logic [2*SAMPLE_BITS-1:0]      xx_out,
    output logic [2*SAMPLE_BITS-1:0]      yy_out,
    output logic                          y_zero,
    output logic                          last_out
);

    localparam logic signed [20:0] INV_K = 21'(INV_SQRT3_Q);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_BITS-1:0]  x_reg;
    logic signed [SAMPLE_BITS+20:0] t_reg;
    logic [2*SAMPLE_BITS-1:0]       xx_reg;
    logic [2*SAMPLE_BITS-1:0]       yy_reg;
    logic                           yz_reg;
    logic                           last_reg;

    logic signed [SAMPLE_BITS+20:0]  t_prod;
    logic signed [2*SAMPLE_BITS-1:0] xx_prod;
    logic signed [2*SAMPLE_BITS-1:0] yy_prod;
    logic                            load;

    // t = y / sqrt3 in Q.(SAMPLE_BITS-1+20); squares feed the sector test
    assign t_prod  = (SAMPLE_BITS+21)'(imag_part) * (SAMPLE_BITS+21)'(INV_K);
    assign xx_prod = (2*SAMPLE_BITS)'(real_part) * (2*SAMPLE_BITS)'(real_part);
    assign yy_prod = (2*SAMPLE_BITS)'(imag_part) * (2*SAMPLE_BITS)'(imag_part);

    assign in_ready = ~valid_reg | out_ready;
    assign load     = in_valid & in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= real_part;
            t_reg    <= t_prod;
            xx_reg   <= xx_prod;
            yy_reg   <= yy_prod;
            yz_reg   <= (imag_part == '0);
            last_reg <= last_pixel;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign t_out     = t_reg;
    assign xx_out    = xx_reg;
    assign yy_out    = yy_reg;
    assign y_zero    = yz_reg;
    assign last_out  = last_reg;

endmodule

// ----- hw/rtl/bte_decide.sv -----
module bte_decide
    import bte_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int WA = SAMPLE_BITS + 22
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  x_in,
    input  logic signed [SAMPLE_BITS+20:0] t_in,
    input  logic [2*SAMPLE_BITS-1:0]       xx_in,
    input  logic [2*SAMPLE_BITS-1:0]       yy_in,
    input  logic                           y_zero,
    input  logic                           last_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [WA-1:0]           first_out,
    output logic signed [WA-1:0]           second_out,
    output bte_ctl_t                       ctl_out
);

    // stage 2: sector and the three candidate sums
    logic              v2_reg;
    logic              v2_next;
    logic signed [WA-1:0] p_reg;
    logic signed [WA-1:0] q_reg;
    logic signed [WA-1:0] d_reg;
    bte_ctl_t          c2_reg;

    // stage 3: weights picked for the sector
    logic              v3_reg;
    logic              v3_next;
    logic signed [WA-1:0] f_reg;
    logic signed [WA-1:0] s_reg;
    bte_ctl_t          c3_reg;

    logic [2*SAMPLE_BITS+1:0] xx3;
    logic                     steep;
    logic [1:0]               sec;
    logic signed [WA-1:0]     xs_w;
    logic signed [WA-1:0]     t_w;
    logic signed [WA-1:0]     f_sel;
    logic signed [WA-1:0]     s_sel;
    logic                     rdy2;
    logic                     x_neg;

    assign x_neg = x_in[SAMPLE_BITS-1];
    assign xx3   = {2'b00, xx_in} + {1'b0, xx_in, 1'b0};
    assign steep = ({2'b00, yy_in} > xx3);

    // phase 0 lands in sector 0, phase 180 in sector 1
    always_comb
    begin
        if (y_zero)
        begin
            sec = x_neg ? SECTOR_1 : SECTOR_0;
        end
        else if (!t_in[SAMPLE_BITS+20])
        begin
            sec = (!x_neg || steep) ? SECTOR_0 : SECTOR_1;
        end
        else
        begin
            sec = (!x_neg || steep) ? SECTOR_2 : SECTOR_1;
        end
    end

    assign xs_w = WA'(x_in) <<< FRAC_EXTRA;
    assign t_w  = WA'(t_in);

    assign rdy2     = ~v3_reg | out_ready;
    assign in_ready = ~v2_reg | rdy2;

    always_comb
    begin
        v2_next = v2_reg;
        if (in_ready)
        begin
            v2_next = in_valid;
        end
        v3_next = v3_reg;
        if (rdy2)
        begin
            v3_next = v2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            p_reg         <= xs_w + t_w;
            q_reg         <= xs_w - t_w;
            d_reg         <= t_w <<< 1;
            c2_reg.sector <= sec;
            c2_reg.last   <= last_in;
        end
    end

    // sector 0: x+t, 2t   sector 1: t-x, -x-t   sector 2: -2t, x-t
    always_comb
    begin
        case (c2_reg.sector)
            SECTOR_0:
            begin
                f_sel = p_reg;
                s_sel = d_reg;
            end
            SECTOR_1:
            begin
                f_sel = -q_reg;
                s_sel = -p_reg;
            end
            SECTOR_2:
            begin
                f_sel = -d_reg;
                s_sel = q_reg;
            end
            default:
            begin
                f_sel = '0;
                s_sel = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy2)
        begin
            f_reg  <= f_sel;
            s_reg  <= s_sel;
            c3_reg <= c2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign first_out  = f_reg;
    assign second_out = s_reg;
    assign ctl_out    = c3_reg;

endmodule

// ----- hw/rtl/bte_finish.sv -----
module bte_finish
    import bte_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int WA = SAMPLE_BITS + 22
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [WA-1:0]   first_in,
    input  logic signed [WA-1:0]   second_in,
    input  bte_ctl_t               ctl_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] weight_zero,
    output logic [SAMPLE_BITS-1:0] weight_one,
    output logic [SAMPLE_BITS-1:0] weight_two,
    output bte_ctl_t               ctl_out
);

    localparam int RW = WA + 1 - FRAC_EXTRA;
    localparam logic signed [WA:0] HALF_LSB = (WA+1)'(1) <<< (FRAC_EXTRA - 1);

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] w0_reg;
    logic [SAMPLE_BITS-1:0] w1_reg;
    logic [SAMPLE_BITS-1:0] w2_reg;
    bte_ctl_t               ctl_reg;

    logic signed [WA-1:0]   scaled [2];
    logic signed [WA:0]     rnd [2];
    logic [RW-1:0]          rsh [2];
    logic [SAMPLE_BITS-1:0] fin [2];
    logic [SAMPLE_BITS-1:0] w0_n;
    logic [SAMPLE_BITS-1:0] w1_n;
    logic [SAMPLE_BITS-1:0] w2_n;

    assign scaled[0] = first_in;
    assign scaled[1] = second_in;

    // round to nearest, clamp at zero, saturate at full scale
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rnd[i] = (WA+1)'(scaled[i]) + HALF_LSB;
            rsh[i] = rnd[i][WA:FRAC_EXTRA];
            if (scaled[i][WA-1] || (scaled[i] == '0))
            begin
                fin[i] = '0;
            end
            else if (rsh[i][RW-1:SAMPLE_BITS] != '0)
            begin
                fin[i] = '1;
            end
            else
            begin
                fin[i] = rsh[i][SAMPLE_BITS-1:0];
            end
        end
    end

    // first weight on phasor k, second on k+1 mod 3
    always_comb
    begin
        case (ctl_in.sector)
            SECTOR_0:
            begin
                w0_n = fin[0];
                w1_n = fin[1];
                w2_n = '0;
            end
            SECTOR_1:
            begin
                w0_n = '0;
                w1_n = fin[0];
                w2_n = fin[1];
            end
            SECTOR_2:
            begin
                w0_n = fin[1];
                w1_n = '0;
                w2_n = fin[0];
            end
            default:
            begin
                w0_n = '0;
                w1_n = '0;
                w2_n = '0;
            end
        endcase
    end

    assign in_ready = ~valid_reg | out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            w0_reg  <= w0_n;
            w1_reg  <= w1_n;
            w2_reg  <= w2_n;
            ctl_reg <= ctl_in;
        end
    end

    assign out_valid   = valid_reg;
    assign weight_zero = w0_reg;
    assign weight_one  = w1_reg;
    assign weight_two  = w2_reg;
    assign ctl_out     = ctl_reg;

endmodule

// ----- hw/rtl/burckhardt_three_phasor_encoder_unit.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: real_part, imag_part; s_tlast: last_pixel
// m_*       out  m_tvalid/m_tready  m_tdata: weight_zero/one/two; m_tuser: sector;
//                                   m_tlast: last_out
//
// Four register stages: products and squares, sector test and candidate sums,
// per-sector selection and negation, then rounding/saturation into the output
// register. One item per cycle sustained while the output is not stalled.
// Each stage has its own valid bit and takes a new item when empty or when
// the stage after it moves, so bubbles close up and a stall holds every item.
// Reset (rst_n, async) clears only the valid bits.
module burckhardt_three_phasor_encoder_unit
    import bte_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // real_part, imag_part, zero pad
    input  logic                  s_tlast,   // last_pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // weight_zero, weight_one, weight_two, zero pad
    output logic [1:0]            m_tuser,   // sector
    output logic                  m_tlast    // last_out
);

    localparam int WA = SAMPLE_BITS + 22;

    // stage 1 -> 2
    logic                           v1;
    logic                           r1;
    logic signed [SAMPLE_BITS-1:0]  x1;
    logic signed [SAMPLE_BITS+20:0] t1;
    logic [2*SAMPLE_BITS-1:0]       xx1;
    logic [2*SAMPLE_BITS-1:0]       yy1;
    logic                           yz1;
    logic                           last1;

    // stage 3 -> 4
    logic                 v3;
    logic                 r3;
    logic signed [WA-1:0] first3;
    logic signed [WA-1:0] second3;
    bte_ctl_t             ctl3;

    logic [SAMPLE_BITS-1:0] w0;
    logic [SAMPLE_BITS-1:0] w1;
    logic [SAMPLE_BITS-1:0] w2;
    bte_ctl_t               ctl4;

    bte_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .real_part  (s_tdata[SAMPLE_BITS-1:0]),
        .imag_part  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .last_pixel (s_tlast),
        .out_valid  (v1),
        .out_ready  (r1),
        .x_out      (x1),
        .t_out      (t1),
        .xx_out     (xx1),
        .yy_out     (yy1),
        .y_zero     (yz1),
        .last_out   (last1)
    );

    bte_decide #(.SAMPLE_BITS(SAMPLE_BITS)) u_decide
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1),
        .in_ready   (r1),
        .x_in       (x1),
        .t_in       (t1),
        .xx_in      (xx1),
        .yy_in      (yy1),
        .y_zero     (yz1),
        .last_in    (last1),
        .out_valid  (v3),
        .out_ready  (r3),
        .first_out  (first3),
        .second_out (second3),
        .ctl_out    (ctl3)
    );

    bte_finish #(.SAMPLE_BITS(SAMPLE_BITS)) u_finish
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v3),
        .in_ready    (r3),
        .first_in    (first3),
        .second_in   (second3),
        .ctl_in      (ctl3),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .weight_zero (w0),
        .weight_one  (w1),
        .weight_two  (w2),
        .ctl_out     (ctl4)
    );

    assign m_tdata = OUT_DATA_W'({w2, w1, w0});
    assign m_tuser = ctl4.sector;
    assign m_tlast = ctl4.last;

    // sector code on the output is always a real sector
    a_sector_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == SECTOR_0 || m_tuser == SECTOR_1 || m_tuser == SECTOR_2))
        else $error("bad sector code on output");

    // the phasor not used by the sector carries zero weight
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == SECTOR_0 && w2 == '0) ||
                      (m_tuser == SECTOR_1 && w0 == '0) ||
                      (m_tuser == SECTOR_2 && w1 == '0)))
        else $error("unused phasor weight not zero");

    // input backs up only when the whole pipe is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && v1 && v3))
        else $error("input stalled with room in the pipeline");

    // an output item held while m_tready is low must not be dropped
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output item dropped");

endmodule
